// ===== sv/dte_pkg.sv =====
// ----------------------------------------------------------------------------
// dte_pkg
// Types, constants and calendar tables for the date/time to epoch converter.
// ----------------------------------------------------------------------------
package dte_pkg;

    // Calendar constants
    localparam int EPOCH_YEAR     = 17;
    localparam int CENTURY_YEAR   = 100;
    localparam int LAST_YEAR      = 99;
    localparam int DAYS_PER_YEAR  = 365;
    localparam int HOURS_PER_DAY  = 24;
    localparam int MIN_PER_HOUR   = 60;
    localparam int SEC_PER_MIN    = 60;
    localparam int MAX_HOUR       = 23;
    localparam int MAX_MINUTE     = 59;
    localparam int MAX_SECOND     = 60;
    localparam int MONTHS         = 12;
    localparam int FEBRUARY       = 2;
    // leap days from the epoch's base, (EPOCH_YEAR - 1) / 4
    localparam int EPOCH_LEAP_OFS = (EPOCH_YEAR - 1) / 4;
    localparam logic [31:0] MAX_EPOCH = 32'd2650752000;

    // Field widths inside the pipeline
    localparam int YEAR_W = 7;
    localparam int DAYS_W = 15;
    localparam int HRS_W  = 20;
    localparam int MINS_W = 26;
    localparam int SECS_W = 32;

    // Request: one date and time as raw bytes
    typedef struct packed {
        logic [7:0] day_of_month;
        logic [7:0] month;
        logic [7:0] year_of_century;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
    } t_date_req;

    // Result: seconds since epoch with valid flag
    typedef struct packed {
        logic [31:0] epoch_seconds;
        logic        valid_res;
    } t_epoch_res;

    // Day-count stage output; zeroed fields when the request was invalid
    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
        logic              ok;
    } t_day_stage;

    // Length of a month in a common year, index 0 = January
    function automatic logic [4:0] month_len(input logic [3:0] idx);
        logic [4:0] len;
        unique case (idx)
            4'd1:                      len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // Days of a common year before the first of each month
    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] ds;
        unique case (idx)
            4'd0:    ds = 9'd0;
            4'd1:    ds = 9'd31;
            4'd2:    ds = 9'd59;
            4'd3:    ds = 9'd90;
            4'd4:    ds = 9'd120;
            4'd5:    ds = 9'd151;
            4'd6:    ds = 9'd181;
            4'd7:    ds = 9'd212;
            4'd8:    ds = 9'd243;
            4'd9:    ds = 9'd273;
            4'd10:   ds = 9'd304;
            4'd11:   ds = 9'd334;
            default: ds = 9'd0;
        endcase
        return ds;
    endfunction

endpackage

// ===== sv/dte_in_if.sv =====
// ----------------------------------------------------------------------------
// dte_in_if
// Request channel carrying one raw date and time.
// ----------------------------------------------------------------------------
interface dte_in_if;
    import dte_pkg::*;

    logic      valid;
    logic      ready;
    t_date_req req;

    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface

// ===== sv/dte_out_if.sv =====
// ----------------------------------------------------------------------------
// dte_out_if
// Result channel carrying epoch seconds and the valid flag.
// ----------------------------------------------------------------------------
interface dte_out_if;
    import dte_pkg::*;

    logic       valid;
    logic       ready;
    t_epoch_res res;

    modport source (output valid, output res, input ready);
    modport sink   (input valid, input res, output ready);
endinterface

// ===== sv/dte_day.sv =====
// ----------------------------------------------------------------------------
// dte_day
// First stage: range checks and day count since the epoch.
// ----------------------------------------------------------------------------
module dte_day (
    input  logic                i_clk,
    input  logic                i_rst_n,
    dte_in_if.sink              i_date,
    output logic                o_valid,
    input  logic                i_ready,
    output dte_pkg::t_day_stage o_day
);
    import dte_pkg::*;

    logic               r_valid;
    t_day_stage         r_day;
    t_day_stage         n_day;
    logic               stage_ready;
    logic [YEAR_W-1:0]  year;
    logic               year_ok;
    logic               leap;
    logic               month_ok;
    logic [3:0]         mon_idx;
    logic [5:0]         day_lim;
    logic               day_ok;
    logic               time_ok;
    logic               all_ok;
    logic [DAYS_W-1:0]  year_days;
    logic [DAYS_W-1:0]  leap_days;
    logic [DAYS_W-1:0]  total_days;

    // Stage advances when empty or when the next stage takes its request
    assign stage_ready  = !r_valid || i_ready;
    assign i_date.ready = stage_ready;

    // Year decode: 0 is 2100, 17..99 direct, anything else invalid
    always_comb begin
        year_ok = 1'b1;
        year    = YEAR_W'(EPOCH_YEAR);
        if (i_date.req.year_of_century == 8'd0) begin
            year = YEAR_W'(CENTURY_YEAR);
        end else if (i_date.req.year_of_century >= 8'(EPOCH_YEAR) &&
                     i_date.req.year_of_century <= 8'(LAST_YEAR)) begin
            year = i_date.req.year_of_century[YEAR_W-1:0];
        end else begin
            year_ok = 1'b0;
        end
    end

    assign leap = (year[1:0] == 2'b00) && (year != YEAR_W'(CENTURY_YEAR));

    // Month and day checks; leap day only in February
    assign month_ok = (i_date.req.month >= 8'd1) && (i_date.req.month <= 8'(MONTHS));
    assign mon_idx  = 4'(i_date.req.month - 8'd1);
    assign day_lim  = {1'b0, month_len(mon_idx)} +
                      6'((i_date.req.month == 8'(FEBRUARY)) && leap);
    assign day_ok   = (i_date.req.day_of_month != 8'd0) &&
                      (i_date.req.day_of_month <= {2'b00, day_lim});
    assign time_ok  = (i_date.req.hour <= 8'(MAX_HOUR)) &&
                      (i_date.req.minute <= 8'(MAX_MINUTE)) &&
                      (i_date.req.second <= 8'(MAX_SECOND));
    assign all_ok   = year_ok && month_ok && day_ok && time_ok;

    // Day count: whole years, leap days of past years, month offset, day
    assign year_days  = DAYS_W'(year - YEAR_W'(EPOCH_YEAR)) * DAYS_W'(DAYS_PER_YEAR);
    assign leap_days  = DAYS_W'((year - YEAR_W'(1)) >> 2) - DAYS_W'(EPOCH_LEAP_OFS);
    assign total_days = year_days + leap_days + DAYS_W'(month_start(mon_idx)) +
                        DAYS_W'((i_date.req.month > 8'(FEBRUARY)) && leap) +
                        DAYS_W'(i_date.req.day_of_month - 8'd1);

    // Invalid requests carry all-zero fields so the result comes out zero
    always_comb begin
        n_day = '0;
        if (all_ok) begin
            n_day.days   = total_days;
            n_day.hour   = i_date.req.hour[4:0];
            n_day.minute = i_date.req.minute[5:0];
            n_day.second = i_date.req.second[5:0];
            n_day.ok     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (stage_ready) begin
            r_valid <= i_date.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_ready && i_date.valid) begin
            r_day <= n_day;
        end
    end

    assign o_valid = r_valid;
    assign o_day   = r_day;

endmodule

// ===== sv/dte_time.sv =====
// ----------------------------------------------------------------------------
// dte_time
// Three multiply-add stages: days to hours, hours to minutes, minutes to
// seconds. The last stage is the output register.
// ----------------------------------------------------------------------------
module dte_time (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  dte_pkg::t_day_stage i_day,
    dte_out_if.source           o_epoch
);
    import dte_pkg::*;

    logic              r_hrs_valid;
    logic [HRS_W-1:0]  r_hrs;
    logic [5:0]        r_hrs_min;
    logic [5:0]        r_hrs_sec;
    logic              r_hrs_ok;
    logic              r_min_valid;
    logic [MINS_W-1:0] r_mins;
    logic [5:0]        r_min_sec;
    logic              r_min_ok;
    logic              r_out_valid;
    t_epoch_res        r_out;
    logic [HRS_W-1:0]  n_hrs;
    logic [MINS_W-1:0] n_mins;
    logic [SECS_W-1:0] n_secs;
    logic              hrs_ready;
    logic              min_ready;
    logic              out_ready;

    // Per-stage ready so bubbles collapse under a stall
    assign out_ready = !r_out_valid || o_epoch.ready;
    assign min_ready = !r_min_valid || out_ready;
    assign hrs_ready = !r_hrs_valid || min_ready;
    assign o_ready   = hrs_ready;

    assign n_hrs  = HRS_W'(i_day.days) * HRS_W'(HOURS_PER_DAY) + HRS_W'(i_day.hour);
    assign n_mins = MINS_W'(r_hrs) * MINS_W'(MIN_PER_HOUR) + MINS_W'(r_hrs_min);
    assign n_secs = SECS_W'(r_mins) * SECS_W'(SEC_PER_MIN) + SECS_W'(r_min_sec);

    // Hours stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hrs_valid <= 1'b0;
        end else if (hrs_ready) begin
            r_hrs_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hrs_ready && i_valid) begin
            r_hrs     <= n_hrs;
            r_hrs_min <= i_day.minute;
            r_hrs_sec <= i_day.second;
            r_hrs_ok  <= i_day.ok;
        end
    end

    // Minutes stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_valid <= 1'b0;
        end else if (min_ready) begin
            r_min_valid <= r_hrs_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (min_ready && r_hrs_valid) begin
            r_mins    <= n_mins;
            r_min_sec <= r_hrs_sec;
            r_min_ok  <= r_hrs_ok;
        end
    end

    // Seconds stage, holds the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_min_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_min_valid) begin
            r_out.epoch_seconds <= n_secs;
            r_out.valid_res     <= r_min_ok;
        end
    end

    assign o_epoch.valid = r_out_valid;
    assign o_epoch.res   = r_out;

endmodule

// ===== sv/date_time_to_epoch_seconds.sv =====
// ----------------------------------------------------------------------------
// date_time_to_epoch_seconds
// Converts a raw UTC date and time to seconds since 2017-01-01 00:00:00.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the output side keeps up; a stall on
// the output holds the pipeline with no loss. The four register stages are
// the range check with day count, then one constant multiply-add each for
// hours, minutes and seconds; the output register is the last of them. Year
// byte 17..99 is 2017..2099 and 0 is 2100; second 60 is accepted. Any
// out-of-range field yields zero seconds with valid_res cleared.
module date_time_to_epoch_seconds (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dte_in_if.sink     i_date,
    dte_out_if.source  o_epoch
);
    import dte_pkg::*;

    logic       day_valid;
    logic       day_ready;
    t_day_stage day_data;

    dte_day u_day (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_date  (i_date),
        .o_valid (day_valid),
        .i_ready (day_ready),
        .o_day   (day_data)
    );

    dte_time u_time (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (day_valid),
        .o_ready (day_ready),
        .i_day   (day_data),
        .o_epoch (o_epoch)
    );

    // A rejected request leaves the first stage with all fields zeroed
    a_reject_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        day_valid && !day_data.ok |->
            day_data.days == '0 && day_data.hour == '0 &&
            day_data.minute == '0 && day_data.second == '0)
        else $error("rejected request carries nonzero fields");

    // Invalid result must read as zero seconds
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_epoch.valid && !o_epoch.res.valid_res |-> o_epoch.res.epoch_seconds == '0)
        else $error("invalid result with nonzero seconds");

    // Valid result never exceeds the last second of 2100
    a_max_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_epoch.valid && o_epoch.res.valid_res |-> o_epoch.res.epoch_seconds <= MAX_EPOCH)
        else $error("epoch seconds beyond range");

endmodule

// ===== tb/epoch_checker.sv =====
// ----------------------------------------------------------------------------
// epoch_checker
// Watches the date and epoch channels, predicts each result and compares.
// ----------------------------------------------------------------------------
// Every accepted date request is converted to its expected epoch seconds and
// valid flag and queued. Each accepted result is compared field by field with
// the oldest queued expectation. A result with nothing queued also fails.
// The mismatch count and the number of outstanding results go to the top.
module epoch_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    dte_in_if    i_date,
    dte_out_if   i_epoch,
    output int   o_fail_count,
    output int   o_pending
);
    import dte_pkg::*;

    // Common-year month lengths and days before each month, January first
    localparam int unsigned DAYS_IN_MONTH [12] = '{
        31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
    };
    localparam int unsigned DAYS_BEFORE_MONTH [12] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
    };

    t_epoch_res pending_epochs[$];
    t_epoch_res want;
    int         mismatches = 0;

    // Convert one raw date to seconds since 2017-01-01 00:00:00
    function automatic t_epoch_res date_to_epoch(input t_date_req d);
        int unsigned year;
        int unsigned leap;
        int unsigned month_days;
        int unsigned day_count;
        logic        in_range;
        t_epoch_res  r;
        in_range = 1'b1;
        // year byte 0 stands for 2100
        if (d.year_of_century == 8'd0) begin
            year = CENTURY_YEAR;
        end else if (d.year_of_century >= EPOCH_YEAR && d.year_of_century <= LAST_YEAR) begin
            year = d.year_of_century;
        end else begin
            year     = EPOCH_YEAR;
            in_range = 1'b0;
        end
        leap = ((year % 4) == 0 && year != CENTURY_YEAR) ? 1 : 0;

        // day limit depends on month, plus leap day in February only
        if (d.month < 1 || d.month > MONTHS) begin
            in_range = 1'b0;
        end else begin
            month_days = DAYS_IN_MONTH[d.month - 1] + ((d.month == FEBRUARY) ? leap : 0);
            if (d.day_of_month < 1 || d.day_of_month > month_days)
                in_range = 1'b0;
        end
        if (d.hour > MAX_HOUR || d.minute > MAX_MINUTE || d.second > MAX_SECOND)
            in_range = 1'b0;

        r = '0;
        if (in_range) begin
            // whole years, leap days of 2020..year-1, then months and days
            day_count = (year - EPOCH_YEAR) * DAYS_PER_YEAR
                      + ((year - 1) / 4 - EPOCH_LEAP_OFS)
                      + DAYS_BEFORE_MONTH[d.month - 1]
                      + ((d.month > FEBRUARY) ? leap : 0)
                      + d.day_of_month - 1;
            r.epoch_seconds = ((day_count * HOURS_PER_DAY + d.hour) * MIN_PER_HOUR
                              + d.minute) * SEC_PER_MIN + d.second;
            r.valid_res     = 1'b1;
        end
        return r;
    endfunction

    // Queue expectations on requests, compare on results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_epoch.valid && i_epoch.ready) begin
                if (pending_epochs.size() == 0) begin
                    $error("result with no request outstanding: epoch_seconds %0d valid_res %0b",
                           i_epoch.res.epoch_seconds, i_epoch.res.valid_res);
                    mismatches++;
                end else begin
                    want = pending_epochs.pop_front();
                    if (i_epoch.res.epoch_seconds !== want.epoch_seconds) begin
                        $error("epoch_seconds: expected %0d, got %0d",
                               want.epoch_seconds, i_epoch.res.epoch_seconds);
                        mismatches++;
                    end
                    if (i_epoch.res.valid_res !== want.valid_res) begin
                        $error("valid_res: expected %0b, got %0b",
                               want.valid_res, i_epoch.res.valid_res);
                        mismatches++;
                    end
                end
            end
            if (i_date.valid && i_date.ready)
                pending_epochs.push_back(date_to_epoch(i_date.req));
        end
        o_pending    <= pending_epochs.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the date/time to epoch seconds converter.
// ----------------------------------------------------------------------------
// A directed set covers the epoch start, the last second of 2100, leap days,
// year 2100, day zero, the leap second and every field just out of range.
// Random requests follow: mostly well-formed dates, some with one field
// broken, some raw noise. The request side sends in bursts with random gaps;
// the result side switches between open, random, sparse and held ready.
// The checker predicts and compares; this module gives the verdict.
module testbench;
    import dte_pkg::*;

    typedef enum int {FLD_DAY, FLD_MONTH, FLD_YEAR, FLD_HOUR, FLD_MINUTE, FLD_SECOND} t_field;
    typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_HOLD} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending_count;
    int   burst_left;

    dte_in_if  date_ch();
    dte_out_if epoch_ch();

    // 10-unit clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    date_time_to_epoch_seconds dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_date  (date_ch),
        .o_epoch (epoch_ch)
    );

    epoch_checker u_epoch_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_date       (date_ch),
        .i_epoch      (epoch_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    function automatic t_date_req make_date(input int day, input int mon, input int yr,
                                            input int hr, input int mi, input int se);
        t_date_req d;
        d.day_of_month    = day[7:0];
        d.month           = mon[7:0];
        d.year_of_century = yr[7:0];
        d.hour            = hr[7:0];
        d.minute          = mi[7:0];
        d.second          = se[7:0];
        return d;
    endfunction

    // Mostly well-formed dates; some with one field broken; some raw noise
    function automatic t_date_req random_date();
        t_date_req d;
        int        pick;
        int        yr;
        t_field    bad;
        pick = $urandom_range(0, 99);
        if (pick >= 85) begin
            d = t_date_req'(48'({$urandom, $urandom}));
        end else begin
            case ($urandom_range(0, 9))
                0:       yr = 0;
                1:       yr = EPOCH_YEAR;
                2:       yr = LAST_YEAR;
                default: yr = $urandom_range(EPOCH_YEAR, LAST_YEAR);
            endcase
            d = make_date(($urandom_range(0, 3) == 0) ? $urandom_range(29, 31)
                                                       : $urandom_range(1, 28),
                          $urandom_range(1, MONTHS), yr,
                          $urandom_range(0, MAX_HOUR), $urandom_range(0, MAX_MINUTE),
                          ($urandom_range(0, 19) == 0) ? MAX_SECOND
                                                       : $urandom_range(0, MAX_SECOND));
            // break one field by setting it to a value outside its range
            if (pick >= 70) begin
                bad = t_field'($urandom_range(0, 5));
                case (bad)
                    FLD_DAY:    d.day_of_month    = $urandom_range(0, 1) ? 8'd0
                                                    : 8'($urandom_range(32, 255));
                    FLD_MONTH:  d.month           = $urandom_range(0, 1) ? 8'd0
                                                    : 8'($urandom_range(13, 255));
                    FLD_YEAR:   d.year_of_century = $urandom_range(0, 1)
                                                    ? 8'($urandom_range(1, 16))
                                                    : 8'($urandom_range(100, 255));
                    FLD_HOUR:   d.hour            = 8'($urandom_range(24, 255));
                    FLD_MINUTE: d.minute          = 8'($urandom_range(60, 255));
                    default:    d.second          = 8'($urandom_range(61, 255));
                endcase
            end
        end
        return d;
    endfunction

    // Send one request; a new burst starts after a random gap
    task automatic send_date(input t_date_req d);
        if (burst_left == 0) begin
            date_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        date_ch.valid <= 1'b1;
        date_ch.req   <= d;
        do @(posedge i_clk); while (!date_ch.ready);
    endtask

    // Result-side ready: a sequence of modes of random length
    initial begin
        t_rx_mode mode;
        int       span;
        epoch_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            span = (mode == RX_HOLD) ? $urandom_range(5, 30) : $urandom_range(10, 60);
            repeat (span) begin
                case (mode)
                    RX_OPEN:   epoch_ch.ready <= 1'b1;
                    RX_RANDOM: epoch_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: epoch_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:   epoch_ch.ready <= 1'b0;
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Reset, directed requests, random requests, drain, verdict
    initial begin
        t_date_req directed[$];
        date_ch.valid <= 1'b0;
        date_ch.req   <= '0;
        i_rst_n       <= 1'b0;
        burst_left = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed.push_back(make_date(1, 1, 17, 0, 0, 0));        // epoch start
        directed.push_back(make_date(31, 12, 0, 23, 59, 60));    // largest count
        directed.push_back(make_date(0, 0, 0, 0, 0, 0));
        directed.push_back(make_date(255, 255, 255, 255, 255, 255));
        directed.push_back(make_date(29, 2, 20, 12, 0, 0));      // leap day
        directed.push_back(make_date(29, 2, 21, 0, 0, 0));       // no leap day
        directed.push_back(make_date(29, 2, 0, 0, 0, 0));        // 2100 not leap
        directed.push_back(make_date(28, 2, 0, 23, 59, 59));
        directed.push_back(make_date(1, 3, 20, 0, 0, 0));        // after leap day
        directed.push_back(make_date(1, 3, 0, 0, 0, 0));
        directed.push_back(make_date(0, 5, 30, 1, 1, 1));        // day zero
        directed.push_back(make_date(15, 0, 30, 8, 8, 8));
        directed.push_back(make_date(15, 13, 30, 8, 8, 8));
        directed.push_back(make_date(1, 1, 16, 0, 0, 0));
        directed.push_back(make_date(1, 1, 100, 0, 0, 0));
        directed.push_back(make_date(1, 1, 1, 0, 0, 0));
        directed.push_back(make_date(1, 6, 50, 24, 0, 0));
        directed.push_back(make_date(1, 6, 50, 23, 60, 0));
        directed.push_back(make_date(1, 6, 50, 23, 59, 61));
        directed.push_back(make_date(30, 6, 50, 23, 59, 60));    // leap second
        directed.push_back(make_date(1, 7, 50, 0, 0, 0));        // same count as above
        directed.push_back(make_date(31, 4, 40, 0, 0, 0));
        directed.push_back(make_date(31, 12, 99, 23, 59, 59));
        directed.push_back(make_date(32, 1, 17, 0, 0, 0));
        directed.push_back(make_date(29, 2, 96, 6, 30, 30));
        foreach (directed[i]) send_date(directed[i]);

        repeat (400) send_date(random_date());
        date_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending_count != 0);
        repeat (12) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** date_time_to_epoch_seconds: PASSED **");
        end else begin
            $display("** date_time_to_epoch_seconds: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("** date_time_to_epoch_seconds: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
sv/dte_pkg.sv
sv/dte_in_if.sv
sv/dte_out_if.sv
sv/dte_day.sv
sv/dte_time.sv
sv/date_time_to_epoch_seconds.sv
tb/epoch_checker.sv
tb/testbench.sv
